// ===== sv/llf_pkg.sv =====
// Shared constants, request/response types and clip helpers for the ladder low-pass filter.
// Used by llf_smul, ladder_lowpass_filter_unit and llf_chk. No dependencies.
package llf_pkg;

	localparam int NUM_POLES = 4;
	localparam int SMP_W     = 16;
	localparam int COEF_FRAC = 16;
	localparam int PIDX_W    = (NUM_POLES > 1) ? $clog2(NUM_POLES) : 1;

	// running value after the quartering, feedback value, multiplier operand
	localparam int X_W    = SMP_W + 1;
	localparam int FB_W   = SMP_W + 2;
	localparam int DIFF_W = FB_W + 1;
	localparam int D_W    = SMP_W + 2;

	// multiplicand holds either the signed cutoff or the unsigned feedback gain
	localparam int CUT_W  = 18;
	localparam int GAIN_W = 19;
	localparam int CLIP_W = 15;
	localparam int M_W    = GAIN_W + 1;
	localparam int ACC_W  = M_W + 1;
	localparam int RND_W  = ACC_W + D_W - COEF_FRAC;
	localparam int CW     = RND_W + 1;
	localparam int CNT_W  = $clog2(D_W + 1);

	// APB register map
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int REG_W  = ADDR_W - 2;
	localparam logic [REG_W-1:0] REG_CUTOFF = 2'd0;
	localparam logic [REG_W-1:0] REG_FBGAIN = 2'd1;
	localparam logic [REG_W-1:0] REG_CLIP   = 2'd2;

	localparam logic [CUT_W-1:0]  CUTOFF_RST = 18'd60484;
	localparam logic [GAIN_W-1:0] FBGAIN_RST = 19'd0;
	localparam logic [CLIP_W-1:0] CLIP_RST   = 15'd31130;

	typedef struct packed {
		logic                  start;
		logic signed [M_W-1:0] mcand;
		logic signed [D_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [RND_W-1:0] rnd;
	} mul_rsp_t;

	// symmetric clip to +/- lim
	function automatic logic signed [SMP_W-1:0] clip_val(
		input logic signed [CW-1:0] v,
		input logic [SMP_W-1:0] lim
	);
		logic signed [CW-1:0] hi;
		logic signed [CW-1:0] lo;
		logic signed [SMP_W-1:0] res;
		hi = signed'(CW'(lim));
		lo = -hi;
		if (v > hi) begin
			res = hi[SMP_W-1:0];
		end else if (v < lo) begin
			res = lo[SMP_W-1:0];
		end else begin
			res = v[SMP_W-1:0];
		end
		return res;
	endfunction

	// saturate the rounded feedback product to the feedback register range
	function automatic logic signed [FB_W-1:0] sat_fb(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] hi;
		logic signed [RND_W-1:0] lo;
		logic signed [FB_W-1:0] res;
		hi = RND_W'((64'sd1 <<< (FB_W - 1)) - 64'sd1);
		lo = -hi - RND_W'(1);
		if (v > hi) begin
			res = hi[FB_W-1:0];
		end else if (v < lo) begin
			res = lo[FB_W-1:0];
		end else begin
			res = v[FB_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== sv/llf_smul.sv =====
// Bit-serial signed multiplier with a Q.16 round-to-nearest output.
// Depends on llf_pkg (widths, mul_req_t, mul_rsp_t).
module llf_smul (
	input  logic              clk,
	input  logic              arst_n,
	input  llf_pkg::mul_req_t req,
	output llf_pkg::mul_rsp_t rsp
);
	import llf_pkg::*;

	logic signed [M_W-1:0]   mcand_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [D_W-1:0]          mq_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic signed [ACC_W:0]   addend;
	logic signed [ACC_W:0]   sum;
	logic                    last;

	always_comb begin
		last   = (cnt_q == CNT_W'(D_W - 1));
		addend = mq_q[0] ? (ACC_W + 1)'(mcand_q) : '0;
		// the top multiplier bit carries negative weight
		if (last) begin
			sum = (ACC_W + 1)'(acc_q) - addend;
		end else begin
			sum = (ACC_W + 1)'(acc_q) + addend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// low product bits shift in at the top of the multiplier register
	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.mcand;
			mq_q    <= req.mplier;
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q <= sum[ACC_W:1];
			mq_q  <= {sum[0], mq_q[D_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rnd  = signed'({acc_q, mq_q[D_W-1:COEF_FRAC]}) + RND_W'(mq_q[COEF_FRAC-1]);

endmodule

// ===== sv/ladder_lowpass_filter_unit.sv =====
// Top level of the four-pole resonant ladder low-pass filter with its APB register block.
// Depends on llf_pkg and llf_smul.

// One Q1.15 sample in, one filtered Q1.15 sample out. Every multiply goes through a
// single shared bit-serial multiplier, one multiplier bit per cycle: one multiply per
// pole and one for the feedback step. The input stalls until the previous sample is
// finished, but a new input is taken while the previous result still waits at the
// output. Registers: cutoff_coef at 0x0 (signed Q2.16), feedback_gain at 0x4
// (unsigned Q3.16), clip_limit at 0x8 (unsigned Q0.15); write them only while the
// filter is idle.
module ladder_lowpass_filter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [llf_pkg::ADDR_W-1:0]       paddr,
	input  logic [llf_pkg::DATA_W-1:0]       pwdata,
	output logic [llf_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [llf_pkg::SMP_W-1:0] sample_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [llf_pkg::SMP_W-1:0] sample_out
);
	import llf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ADD1 = 3'd3;
	localparam logic [2:0] S_ADD2 = 3'd4;
	localparam logic [2:0] S_FB   = 3'd5;

	logic [CUT_W-1:0]  cutoff_q;
	logic [GAIN_W-1:0] fbgain_q;
	logic [CLIP_W-1:0] clip_q;

	logic [2:0]              state_q;
	logic [PIDX_W-1:0]       k_q;
	logic                    fbph_q;
	logic signed [X_W-1:0]   x_q;
	logic signed [SMP_W-1:0] t_q;
	logic signed [SMP_W-1:0] v_q;
	logic signed [SMP_W-1:0] pole_q [NUM_POLES];
	logic signed [FB_W-1:0]  fb_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] sample_out_q;

	logic                     cfg_wr;
	logic                     in_accept;
	logic                     out_free;
	logic signed [DIFF_W-1:0] diff;
	logic signed [X_W-1:0]    x0;
	logic [SMP_W-1:0]         lim;
	logic signed [SMP_W-1:0]  v_new;
	logic signed [SMP_W-1:0]  x_new;
	logic signed [FB_W-1:0]   fb_new;
	mul_req_t                 mreq;
	mul_rsp_t                 mrsp;

	llf_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// register block
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RST;
			fbgain_q <= FBGAIN_RST;
			clip_q   <= CLIP_RST;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_CUTOFF: cutoff_q <= pwdata[CUT_W-1:0];
				REG_FBGAIN: fbgain_q <= pwdata[GAIN_W-1:0];
				REG_CLIP:   clip_q   <= pwdata[CLIP_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_CUTOFF: prdata = DATA_W'(cutoff_q);
			REG_FBGAIN: prdata = DATA_W'(fbgain_q);
			REG_CLIP:   prdata = DATA_W'(clip_q);
			default:    prdata = '0;
		endcase
	end

	// datapath
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	always_comb begin
		diff   = DIFF_W'(sample_in) - DIFF_W'(fb_q);
		x0     = diff[DIFF_W-1:2];   // floor of a quarter
		lim    = SMP_W'(clip_q);
		v_new  = clip_val(CW'(x_q) + CW'(mrsp.rnd), lim);
		x_new  = clip_val(CW'(v_q) + CW'(t_q), lim);
		fb_new = sat_fb(mrsp.rnd);

		mreq.start = (state_q == S_LOAD);
		if (fbph_q) begin
			mreq.mcand  = signed'(M_W'(fbgain_q));
			mreq.mplier = D_W'(x_q);
		end else begin
			mreq.mcand  = M_W'(signed'(cutoff_q));
			mreq.mplier = D_W'(x_q) - D_W'(pole_q[k_q]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			fbph_q      <= 1'b0;
			fb_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_POLES; i++) begin
				pole_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FB) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						k_q     <= '0;
						fbph_q  <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_MUL;
				S_MUL: begin
					if (mrsp.done) begin
						state_q <= fbph_q ? S_FB : S_ADD1;
					end
				end
				S_ADD1: begin
					pole_q[k_q] <= v_new;
					state_q     <= S_ADD2;
				end
				S_ADD2: begin
					if (k_q == PIDX_W'(NUM_POLES - 1)) begin
						fbph_q <= 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
					state_q <= S_LOAD;
				end
				S_FB: begin
					// hold here until the output register can take the new sample
					if (out_free) begin
						fb_q        <= fb_new;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_accept) begin
			x_q <= x0;
		end else if (state_q == S_ADD2) begin
			x_q <= X_W'(x_new);
		end
		if (state_q == S_LOAD) begin
			t_q <= pole_q[k_q];
		end
		if (state_q == S_ADD1) begin
			v_q <= v_new;
		end
		if (state_q == S_FB && out_free) begin
			sample_out_q <= x_q[SMP_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

// ===== sv/llf_chk.sv =====
// Port-level checker for ladder_lowpass_filter_unit, bound to the top level below.
// Depends on llf_pkg for port widths.
module llf_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [llf_pkg::SMP_W-1:0] sample_out
);

	// a taken request keeps the input stalled while the sample is worked on
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a request was taken");

	// the input only stalls once a request has been taken
	a_stall_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stalled without a request");

	// a request taken on both sides in one cycle cannot be the same sample
	a_no_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without the filter being busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled result changed or dropped");

endmodule

bind ladder_lowpass_filter_unit llf_chk u_llf_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for ladder_lowpass_filter_unit: drives samples and APB register
// writes, predicts every filtered sample in a scoreboard class. Depends on llf_pkg.
`timescale 1ns / 1ps

module tb;
	import llf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 150;

	// tracks the filter state and holds the filtered samples still owed by the block
	class ladder_scoreboard;
		logic signed [CUT_W-1:0]  cutoff_coef;
		logic        [GAIN_W-1:0] feedback_gain;
		logic        [CLIP_W-1:0] clip_limit;
		logic signed [SMP_W-1:0]  pole_state [NUM_POLES];
		logic signed [FB_W-1:0]   fb_value;
		logic signed [SMP_W-1:0]  owed_out [$];
		int errors;

		function new();
			cutoff_coef   = CUTOFF_RST;
			feedback_gain = FBGAIN_RST;
			clip_limit    = CLIP_RST;
			foreach (pole_state[k]) pole_state[k] = '0;
			fb_value = '0;
			errors   = 0;
		endfunction

		function void set_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_CUTOFF: cutoff_coef   = val[CUT_W-1:0];
				REG_FBGAIN: feedback_gain = val[GAIN_W-1:0];
				REG_CLIP:   clip_limit    = val[CLIP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		// Q2.16 or Q3.16 coefficient product back to sample scale, ties toward plus infinity
		function longint round_coef(longint v);
			return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		endfunction

		function void note_sample(logic signed [SMP_W-1:0] smp);
			longint x, t, v, lim, p, q, fb_max;
			lim    = longint'(clip_limit);
			p      = longint'(cutoff_coef);
			q      = longint'(feedback_gain);
			fb_max = (longint'(1) <<< (FB_W - 1)) - 1;
			x = (longint'(smp) - longint'(fb_value)) >>> 2;
			for (int k = 0; k < NUM_POLES; k++) begin
				t = longint'(pole_state[k]);
				v = clamp(x + round_coef(p * (x - t)), -lim, lim);
				pole_state[k] = v[SMP_W-1:0];
				x = clamp(v + t, -lim, lim);
			end
			owed_out.push_back(x[SMP_W-1:0]);
			v = clamp(round_coef(x * q), -fb_max - 1, fb_max);
			fb_value = v[FB_W-1:0];
		endfunction

		function void check_sample(logic signed [SMP_W-1:0] got);
			logic signed [SMP_W-1:0] want;
			if (owed_out.size() == 0) begin
				$display("%0t: unexpected sample_out, expected none, actual %0d", $time, got);
				errors++;
			end else begin
				want = owed_out.pop_front();
				if (got !== want) begin
					$display("%0t: sample_out mismatch, expected %0d, actual %0d",
						$time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return owed_out.size();
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [SMP_W-1:0] sample_in = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [SMP_W-1:0] sample_out;

	ladder_scoreboard ladder = new();
	int send_idle_pct = 7;
	int recv_idle_pct = 68;
	int cycles = 0;

	ladder_lowpass_filter_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (out_valid && !out_stall) begin
			ladder.check_sample(sample_out);
		end
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// all tasks are entered in the time step of a rising edge
	task automatic send_sample(input logic signed [SMP_W-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ladder.note_sample(smp);
	endtask

	// sender holds off until every owed sample has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ladder.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		ladder.set_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_all(input int cut, input int gain, input int clip);
		write_reg(REG_CUTOFF, cut);
		write_reg(REG_FBGAIN, gain);
		write_reg(REG_CLIP, clip);
	endtask

	// extremes often, in-range values mostly, now and then raw contents (for clip, mostly raw)
	task automatic write_random_regs();
		int cut, gain, clip;
		case ($urandom_range(5))
			0: cut = -66060;
			1: cut = 65536;
			2: cut = $urandom;
			default: cut = int'($urandom_range(131596)) - 66060;
		endcase
		case ($urandom_range(5))
			0: gain = 0;
			1: gain = 262144;
			2: gain = $urandom;
			default: gain = $urandom_range(262144);
		endcase
		case ($urandom_range(5))
			0: clip = 0;
			1: clip = 32767;
			2: clip = 31130;
			default: clip = $urandom;
		endcase
		write_all(cut, gain, clip);
	endtask

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return SMP_W'(int'($urandom_range(2047)) - 1024);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	initial begin
		int done_items;
		int burst;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full-scale steps and the smallest values
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		send_sample(16'shffff);

		// top cutoff, 4.0 feedback, widest clip
		wait_drained();
		write_all(65536, 262144, 32767);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh3039);

		// zero clip forces silence, then a one-LSB clip
		wait_drained();
		write_all(-66060, 32'h0007_ffff, 0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		wait_drained();
		write_reg(REG_CLIP, 1);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);

		// out-of-range cutoff and feedback gain past 4.0, so the feedback saturates
		wait_drained();
		write_all(32'hfffe_0000, 32'h0007_ffff, 32767);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 7;  recv_idle_pct = 68; end
				1: begin send_idle_pct = 68; recv_idle_pct = 7;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			done_items = 0;
			while (done_items < 310) begin
				wait_drained();
				write_random_regs();
				burst = $urandom_range(20, 70);
				if (burst > 310 - done_items) burst = 310 - done_items;
				repeat (burst) send_sample(rand_sample());
				done_items += burst;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ladder.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/llf_pkg.sv
sv/llf_smul.sv
sv/ladder_lowpass_filter_unit.sv
sv/llf_chk.sv
tb/tb.sv
